// File: design/mx4inv_pkg.sv
// Shared types, constants and index tables for the 4x4 matrix inverse unit.
// No dependencies; used by the top level and the testbench.
package mx4inv_pkg;

	localparam int ELEM_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] element_value;
		logic                         restart;
	} in_item_t;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] inverse_value;
		logic [3:0]                   element_index;
		logic                         last_element;
		logic signed [ELEM_WIDTH-1:0] determinant;
		logic                         singular;
		logic                         saturated;
	} out_item_t;

	// 2x2 minor k = m[p]*m[q] - m[r]*m[s]; 0..5 upper rows, 6..11 lower rows
	localparam logic [3:0] MINOR_TAB [12][4] = '{
		'{4'd0, 4'd5, 4'd1, 4'd4}, '{4'd0, 4'd6, 4'd2, 4'd4}, '{4'd0, 4'd7, 4'd3, 4'd4},
		'{4'd1, 4'd6, 4'd2, 4'd5}, '{4'd1, 4'd7, 4'd3, 4'd5}, '{4'd2, 4'd7, 4'd3, 4'd6},
		'{4'd8, 4'd13, 4'd9, 4'd12}, '{4'd8, 4'd14, 4'd10, 4'd12},
		'{4'd8, 4'd15, 4'd11, 4'd12}, '{4'd9, 4'd14, 4'd10, 4'd13},
		'{4'd9, 4'd15, 4'd11, 4'd13}, '{4'd10, 4'd15, 4'd11, 4'd14}
	};

	// cofactor i = m[e0]*M[k0] - m[e1]*M[k1] + m[e2]*M[k2], then sign
	localparam logic [3:0] COF_TAB [16][6] = '{
		'{4'd5, 4'd11, 4'd6, 4'd10, 4'd7, 4'd9}, '{4'd1, 4'd11, 4'd2, 4'd10, 4'd3, 4'd9},
		'{4'd13, 4'd5, 4'd14, 4'd4, 4'd15, 4'd3}, '{4'd9, 4'd5, 4'd10, 4'd4, 4'd11, 4'd3},
		'{4'd4, 4'd11, 4'd6, 4'd8, 4'd7, 4'd7}, '{4'd0, 4'd11, 4'd2, 4'd8, 4'd3, 4'd7},
		'{4'd12, 4'd5, 4'd14, 4'd2, 4'd15, 4'd1}, '{4'd8, 4'd5, 4'd10, 4'd2, 4'd11, 4'd1},
		'{4'd4, 4'd10, 4'd5, 4'd8, 4'd7, 4'd6}, '{4'd0, 4'd10, 4'd1, 4'd8, 4'd3, 4'd6},
		'{4'd12, 4'd4, 4'd13, 4'd2, 4'd15, 4'd0}, '{4'd8, 4'd4, 4'd9, 4'd2, 4'd11, 4'd0},
		'{4'd4, 4'd9, 4'd5, 4'd7, 4'd6, 4'd6}, '{4'd0, 4'd9, 4'd1, 4'd7, 4'd2, 4'd6},
		'{4'd12, 4'd3, 4'd13, 4'd1, 4'd14, 4'd0}, '{4'd8, 4'd3, 4'd9, 4'd1, 4'd10, 4'd0}
	};

	localparam logic [15:0] COF_NEG = 16'b0101_1010_0101_1010;

endpackage

// File: design/matrix4x4_inverse_cofactor_unit.sv
// Top level of the 4x4 matrix inverse (adjugate method) in signed fixed point.
// Depends on mx4inv_pkg and mx4inv_ram.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): one matrix element per item,
//   row-major. restart marks an element as the first of a matrix. The block
//   takes elements only while loading; 15 items cause no result, the
//   sixteenth starts the computation.
//   Output channel (out_valid/out_ready/out_data): sixteen items, the inverse
//   in row-major order, each carrying the determinant, index, last mark,
//   singular and saturated flags. A singular matrix gives zero values.
//   The computation runs on one shared shift-add multiplier, with operand
//   fetch and accumulate around each product, over 24 minor products, 6
//   determinant products and 48 cofactor products, then a restoring divider
//   (134 quotient bits at one per cycle, after setup and before output) for
//   each inverse element of a non-singular matrix.
//   Elements and minors live in two RAMs; each operand fetch is a read then a latch.
//   Reset clears the load position and the sequencer; the RAMs are not
//   cleared. When the receiver stalls, hold the result until it is taken.
module matrix4x4_inverse_cofactor_unit #(
	parameter int FRAC_BITS = mx4inv_pkg::FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mx4inv_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mx4inv_pkg::out_item_t out_data
);

	localparam int W    = mx4inv_pkg::ELEM_WIDTH;
	localparam int MNW  = 2 * W + 1;            // minor width
	localparam int DW   = 4 * W + 6;            // accumulator width
	localparam int BW   = 2 * W + 1;            // multiplier bits scanned
	localparam int MCW  = $clog2(BW + 1);
	localparam int DENW = 4 * W + 3;
	localparam int RW   = DENW + 1;
	localparam int NW   = ((3 * W + 2 * FRAC_BITS + 4 > 4 * W + 5) ?
		(3 * W + 2 * FRAC_BITS + 4) : (4 * W + 5)) + 1;
	localparam int DCW  = $clog2(NW + 1);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_RDA  = 4'd1;
	localparam logic [3:0] ST_RDB  = 4'd2;
	localparam logic [3:0] ST_MUL0 = 4'd3;
	localparam logic [3:0] ST_MUL  = 4'd4;
	localparam logic [3:0] ST_ACC  = 4'd5;
	localparam logic [3:0] ST_DET  = 4'd6;
	localparam logic [3:0] ST_DETR = 4'd7;
	localparam logic [3:0] ST_DIV0 = 4'd8;
	localparam logic [3:0] ST_DIV1 = 4'd9;
	localparam logic [3:0] ST_DIV  = 4'd10;
	localparam logic [3:0] ST_FIN  = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	localparam logic [1:0] PH_MINOR = 2'd0;
	localparam logic [1:0] PH_DET   = 2'd1;
	localparam logic [1:0] PH_COF   = 2'd2;

	localparam logic [3:0] LAST_MINOR = 4'd11;
	localparam logic [3:0] LAST_DET   = 4'd5;
	localparam logic [3:0] LAST_ELEM  = 4'd15;

	localparam logic [W:0] HALF = (W + 1)'(1) << (W - 1);

	logic [3:0]       state_q;
	logic [1:0]       phase_q;
	logic [3:0]       idx_q;
	logic [1:0]       sub_q;
	logic [3:0]       pos_q;

	logic             a_ram1, b_ram1, term_neg, term_first;
	logic [3:0]       a_addr, b_addr, rd_addr;

	logic             m_we;
	logic [3:0]       m_waddr;
	logic [W-1:0]     m_rdata;
	logic             mn_we;
	logic [MNW-1:0]   mn_rdata;

	logic signed [DW-1:0] opa_q, rd_ext;
	logic [DW-1:0]    mcand_q, prod_q, acc_q, acc_new, acc_base, det_abs_q;
	logic [BW-1:0]    mplier_q;
	logic [MCW-1:0]   mcnt_q;
	logic             psign_q, det_neg_q, sing_q, det_sat_q;
	logic [W-1:0]     det_out_q;
	logic [DW-1:0]    det_round;
	logic [NW-1:0]    num_q;
	logic [RW-1:0]    rem_q, rem_sh, rem_diff;
	logic [W:0]       quo_q, fin_lim, fin_mag, det_lim;
	logic             ovf_q, qneg_q, fin_sat, det_big;
	logic [DCW-1:0]   dcnt_q;
	logic [3:0]       load_pos;
	logic             term_s;
	mx4inv_pkg::out_item_t out_q;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;
	assign load_pos  = in_data.restart ? 4'd0 : pos_q;

	// operand sources for the current term
	always_comb begin
		a_ram1     = 1'b0;
		b_ram1     = 1'b0;
		a_addr     = 4'd0;
		b_addr     = 4'd0;
		term_neg   = 1'b0;
		term_first = 1'b0;
		unique case (phase_q)
			PH_MINOR: begin
				a_addr     = mx4inv_pkg::MINOR_TAB[idx_q][{sub_q[0], 1'b0}];
				b_addr     = mx4inv_pkg::MINOR_TAB[idx_q][{sub_q[0], 1'b1}];
				term_neg   = sub_q[0];
				term_first = (sub_q == 2'd0);
			end
			PH_DET: begin
				a_ram1     = 1'b1;
				b_ram1     = 1'b1;
				a_addr     = idx_q;
				b_addr     = LAST_MINOR - idx_q;
				term_neg   = (idx_q == 4'd1) || (idx_q == 4'd4);
				term_first = (idx_q == 4'd0);
			end
			default: begin
				b_ram1     = 1'b1;
				a_addr     = mx4inv_pkg::COF_TAB[idx_q][{sub_q, 1'b0}];
				b_addr     = mx4inv_pkg::COF_TAB[idx_q][{sub_q, 1'b1}];
				term_neg   = (sub_q == 2'd1) ^ mx4inv_pkg::COF_NEG[idx_q];
				term_first = (sub_q == 2'd0);
			end
		endcase
	end

	assign rd_addr = (state_q == ST_RDB) ? b_addr : a_addr;
	assign m_we    = in_valid && in_ready;
	assign m_waddr = load_pos;
	assign mn_we   = (state_q == ST_ACC) && (phase_q == PH_MINOR) && sub_q[0];

	mx4inv_ram #(.WIDTH(W), .DEPTH(16)) u_elem_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (in_data.element_value),
		.raddr (rd_addr),
		.rdata (m_rdata)
	);

	mx4inv_ram #(.WIDTH(MNW), .DEPTH(12)) u_minor_ram (
		.clk   (clk),
		.we    (mn_we),
		.waddr (idx_q),
		.wdata (acc_new[MNW-1:0]),
		.raddr (rd_addr),
		.rdata (mn_rdata)
	);

	// sign-extend whichever RAM feeds the operand being latched
	always_comb begin
		logic use_ram1;
		use_ram1 = (state_q == ST_RDB) ? a_ram1 : b_ram1;
		if (use_ram1) begin
			rd_ext = {{(DW - MNW){mn_rdata[MNW-1]}}, mn_rdata};
		end else begin
			rd_ext = {{(DW - W){m_rdata[W-1]}}, m_rdata};
		end
	end

	// accumulate: acc +/- product with a carry-in, one adder
	assign term_s   = psign_q ^ term_neg;
	assign acc_base = term_first ? '0 : acc_q;
	assign acc_new  = acc_base + (term_s ? ~prod_q : prod_q) + DW'(term_s);

	// determinant rounding to Q.FRAC_BITS
	assign det_round = (det_abs_q + (DW'(1) << (3 * FRAC_BITS - 1))) >> (3 * FRAC_BITS);
	assign det_lim   = det_neg_q ? HALF : HALF - 1'b1;
	assign det_big   = det_round > DW'(det_lim);

	// restoring division step
	assign rem_sh   = {rem_q[RW-2:0], num_q[NW-1]};
	assign rem_diff = rem_sh - RW'({det_abs_q[DENW-2:0], 1'b0});

	assign fin_lim = qneg_q ? HALF : HALF - 1'b1;
	assign fin_sat = ovf_q || (quo_q > fin_lim);
	assign fin_mag = fin_sat ? fin_lim : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_MINOR;
			idx_q   <= 4'd0;
			sub_q   <= 2'd0;
			pos_q   <= 4'd0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (m_we) begin
						pos_q <= load_pos + 4'd1;
						if (load_pos == LAST_ELEM) begin
							phase_q <= PH_MINOR;
							idx_q   <= 4'd0;
							sub_q   <= 2'd0;
							state_q <= ST_RDA;
						end
					end
				end
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL;
				ST_MUL: begin
					if (mcnt_q == MCW'(BW - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					unique case (phase_q)
						PH_MINOR: begin
							state_q <= ST_RDA;
							if (!sub_q[0]) begin
								sub_q <= 2'd1;
							end else if (idx_q == LAST_MINOR) begin
								phase_q <= PH_DET;
								idx_q   <= 4'd0;
								sub_q   <= 2'd0;
							end else begin
								idx_q <= idx_q + 4'd1;
								sub_q <= 2'd0;
							end
						end
						PH_DET: begin
							if (idx_q == LAST_DET) begin
								state_q <= ST_DET;
							end else begin
								idx_q   <= idx_q + 4'd1;
								state_q <= ST_RDA;
							end
						end
						default: begin
							if (sub_q == 2'd2) begin
								state_q <= ST_DIV0;
							end else begin
								sub_q   <= sub_q + 2'd1;
								state_q <= ST_RDA;
							end
						end
					endcase
				end
				ST_DET: state_q <= ST_DETR;
				ST_DETR: begin
					phase_q <= PH_COF;
					idx_q   <= 4'd0;
					sub_q   <= 2'd0;
					state_q <= sing_q ? ST_FIN : ST_RDA;
				end
				ST_DIV0: state_q <= ST_DIV1;
				ST_DIV1: state_q <= ST_DIV;
				ST_DIV: begin
					if (dcnt_q == DCW'(NW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) begin
						if (idx_q == LAST_ELEM) begin
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + 4'd1;
							sub_q   <= 2'd0;
							state_q <= sing_q ? ST_FIN : ST_RDA;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RDB: begin
				opa_q <= rd_ext;
			end
			ST_MUL0: begin
				// magnitudes into the shift-add multiplier
				mcand_q  <= opa_q[DW-1] ? (~opa_q + 1'b1) : opa_q;
				mplier_q <= rd_ext[DW-1] ? BW'(~rd_ext + 1'b1) : BW'(rd_ext);
				psign_q  <= opa_q[DW-1] ^ rd_ext[DW-1];
				prod_q   <= '0;
				mcnt_q   <= '0;
			end
			ST_MUL: begin
				if (mplier_q[0]) begin
					prod_q <= prod_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				mcnt_q   <= mcnt_q + 1'b1;
			end
			ST_ACC: begin
				acc_q <= acc_new;
			end
			ST_DET: begin
				det_neg_q <= acc_q[DW-1];
				det_abs_q <= acc_q[DW-1] ? (~acc_q + 1'b1) : acc_q;
				sing_q    <= (acc_q == '0);
			end
			ST_DETR: begin
				det_sat_q <= det_big;
				if (det_big) begin
					det_out_q <= det_neg_q ? W'(~det_lim + 1'b1) : W'(det_lim);
				end else begin
					det_out_q <= det_neg_q ? W'(~det_round + 1'b1) : W'(det_round);
				end
			end
			ST_DIV0: begin
				// numerator: 2*|cof|*2^(2F) + |det|, built in two steps
				num_q  <= NW'(acc_q[DW-1] ? (~acc_q + 1'b1) : acc_q) << (2 * FRAC_BITS + 1);
				qneg_q <= acc_q[DW-1] ^ det_neg_q;
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				dcnt_q <= '0;
			end
			ST_DIV1: begin
				num_q <= num_q + NW'(det_abs_q);
			end
			ST_DIV: begin
				if (!rem_diff[RW-1]) begin
					rem_q <= rem_diff;
				end else begin
					rem_q <= rem_sh;
				end
				quo_q  <= {quo_q[W-1:0], ~rem_diff[RW-1]};
				ovf_q  <= ovf_q | quo_q[W];
				num_q  <= num_q << 1;
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_FIN: begin
				out_q.element_index <= idx_q;
				out_q.last_element  <= (idx_q == LAST_ELEM);
				out_q.singular      <= sing_q;
				if (sing_q) begin
					out_q.inverse_value <= '0;
					out_q.determinant   <= '0;
					out_q.saturated     <= 1'b0;
				end else begin
					out_q.inverse_value <= qneg_q ? W'(~fin_mag + 1'b1) : W'(fin_mag);
					out_q.determinant   <= det_out_q;
					out_q.saturated     <= fin_sat | det_sat_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/mx4inv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mx4inv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: verif/matrix4x4_inverse_cofactor_unit_test.sv
// Testbench for matrix4x4_inverse_cofactor_unit: streams matrices and checks
// every inverse element against a wide-integer adjugate predictor.
// Depends on mx4inv_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module matrix4x4_inverse_cofactor_unit_test;

	typedef logic signed [255:0] wide_t;
	typedef logic [255:0] uwide_t;

	localparam int TIMEOUT_CYCLES = 100000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int RANDOM_ITEMS   = 470;
	// sign applied to each cofactor, row-major, leftmost entry first
	localparam logic [0:15] COF_FLIP = 16'b0101_1010_0101_1010;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	mx4inv_pkg::in_item_t  in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	mx4inv_pkg::out_item_t out_data;

	matrix4x4_inverse_cofactor_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mx4inv_pkg::in_item_t  element_queue[$];   // elements waiting to be driven
	mx4inv_pkg::out_item_t inverse_queue[$];   // inverse elements still due from the unit

	// own copy of the unit's state
	logic signed [mx4inv_pkg::ELEM_WIDTH-1:0] shadow_matrix [16];
	logic [3:0] shadow_pos = '0;

	int  sent_count = 0;
	int  mismatch_count = 0;
	int  stall_count = 0;
	bit  in_taken = 0;
	bit  timed_out = 0;

	// idle rates per phase: a slow receiver first, then a slow sender, then no idling
	function automatic int idle_percent(bit receiver);
		if (sent_count < 160)
			return receiver ? 57 : 6;
		else if (sent_count < 320)
			return receiver ? 6 : 57;
		return 0;
	endfunction

	// exact n/d, rounded half away from zero, clipped to the element range
	function automatic logic signed [mx4inv_pkg::ELEM_WIDTH-1:0] div_round_sat(wide_t n,
			wide_t d, inout bit clipped);
		uwide_t an, ad, q, lim;
		bit neg;
		neg = (n < 0) != (d < 0);
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = (2 * an + ad) / (2 * ad);
		lim = neg ? (uwide_t'(1) << (mx4inv_pkg::ELEM_WIDTH - 1)) :
			((uwide_t'(1) << (mx4inv_pkg::ELEM_WIDTH - 1)) - 1);
		if (q > lim) begin
			q = lim;
			clipped = 1;
		end
		return neg ? -q[mx4inv_pkg::ELEM_WIDTH-1:0] : q[mx4inv_pkg::ELEM_WIDTH-1:0];
	endfunction

	// load one element; on the sixteenth, queue the 16 inverse elements
	task automatic load_and_invert(mx4inv_pkg::in_item_t item);
		wide_t m [16];
		wide_t mn [12];
		wide_t det, cof;
		logic signed [mx4inv_pkg::ELEM_WIDTH-1:0] det_q;
		bit det_clip, clip, sing;
		logic [3:0] pos;
		mx4inv_pkg::out_item_t r;
		pos = item.restart ? 4'd0 : shadow_pos;
		shadow_matrix[pos] = item.element_value;
		shadow_pos = pos + 4'd1;
		if (pos != 4'd15)
			return;
		for (int i = 0; i < 16; i++)
			m[i] = shadow_matrix[i];
		for (int k = 0; k < 12; k++)
			mn[k] = m[mx4inv_pkg::MINOR_TAB[k][0]] * m[mx4inv_pkg::MINOR_TAB[k][1]] -
				m[mx4inv_pkg::MINOR_TAB[k][2]] * m[mx4inv_pkg::MINOR_TAB[k][3]];
		det = mn[0] * mn[11] - mn[1] * mn[10] + mn[2] * mn[9] + mn[3] * mn[8]
			- mn[4] * mn[7] + mn[5] * mn[6];
		sing = (det == 0);
		det_clip = 0;
		det_q = sing ? '0 :
			div_round_sat(det, wide_t'(1) <<< (3 * mx4inv_pkg::FRAC_BITS), det_clip);
		for (int i = 0; i < 16; i++) begin
			clip = det_clip;
			r = '0;
			if (!sing) begin
				cof = m[mx4inv_pkg::COF_TAB[i][0]] * mn[mx4inv_pkg::COF_TAB[i][1]]
					- m[mx4inv_pkg::COF_TAB[i][2]] * mn[mx4inv_pkg::COF_TAB[i][3]]
					+ m[mx4inv_pkg::COF_TAB[i][4]] * mn[mx4inv_pkg::COF_TAB[i][5]];
				if (COF_FLIP[i])
					cof = -cof;
				r.inverse_value = div_round_sat(cof <<< (2 * mx4inv_pkg::FRAC_BITS), det,
					clip);
			end
			r.element_index = i[3:0];
			r.last_element  = (i == 15);
			r.determinant   = det_q;
			r.singular      = sing;
			r.saturated     = !sing && clip;
			inverse_queue.push_back(r);
		end
	endtask

	// drive at the falling edge; hold valid and payload until taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (element_queue.size() != 0 && $urandom_range(99) >= idle_percent(0)) begin
				in_data  <= element_queue.pop_front();
				in_valid <= 1'b1;
				sent_count++;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (arst_n)
			out_ready <= ($urandom_range(99) >= idle_percent(1));
	end

	// sample at the rising edge: predict on input, check on output
	always @(posedge clk) begin
		mx4inv_pkg::out_item_t want;
		in_taken = in_valid && in_ready;
		if (in_taken)
			load_and_invert(in_data);
		if (out_valid && out_ready) begin
			if (inverse_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected inverse item %p", out_data);
			end else begin
				want = inverse_queue.pop_front();
				if (out_data !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("inverse mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
		// watchdog: count cycles with no handshake on either side
		if (in_taken || (out_valid && out_ready))
			stall_count = 0;
		else if (arst_n)
			stall_count++;
		if (stall_count >= TIMEOUT_CYCLES) begin
			$display("watchdog expired");
			$display("matrix4x4_inverse_cofactor_unit test failed");
			$finish;
		end
	end

	task automatic push_element(logic [31:0] value, bit first);
		mx4inv_pkg::in_item_t e;
		e.element_value = value;
		e.restart = first;
		element_queue.push_back(e);
	endtask

	// one random matrix of a given flavor, possibly cut short
	task automatic push_matrix(int flavor, inout int pos);
		logic [31:0] v [16];
		int cut;
		for (int i = 0; i < 16; i++) begin
			case (flavor)
				0: v[i] = $urandom_range(1 << 19) - (1 << 18);   // about +-4.0
				1: v[i] = $urandom();                            // full range
				2: v[i] = (i % 5 == 0) ? $urandom_range(1, 3) : 0; // tiny determinant
				default: v[i] = $urandom_range(1 << 17) - (1 << 16);
			endcase
		end
		if (flavor == 3)           // singular: copy row 0 into row 2
			for (int c = 0; c < 4; c++)
				v[8 + c] = v[c];
		if (flavor == 4)           // large diagonal, saturating inverse corner
			for (int c = 0; c < 4; c++)
				v[5 * c] = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
		cut = ($urandom_range(9) == 0) ? $urandom_range(1, 15) : 16;
		for (int i = 0; i < cut; i++)
			push_element(v[i], i == 0 && (pos != 0 || $urandom_range(3) != 0));
		pos = (cut == 16) ? 0 : cut;
	endtask

	initial begin
		int pos;
		int flavor;
		// directed: identity, then a broken start of extremes
		for (int i = 0; i < 16; i++)
			push_element((i % 5 == 0) ? 32'h0001_0000 : 32'h0, i == 0);
		push_element(32'h7fffffff, 1'b1);
		push_element(32'h80000000, 1'b0);
		push_element(32'hffffffff, 1'b0);
		push_element(32'h00000001, 1'b0);
		pos = 4;
		// random: mostly whole matrices, a few cut short
		while (element_queue.size() < RANDOM_ITEMS) begin
			flavor = $urandom_range(9);
			flavor = (flavor < 5) ? 0 : flavor - 4;
			push_matrix(flavor, pos);
		end
		// close the last sequence so every element yields a checkable result
		while (pos != 0)
			push_matrix(0, pos);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		wait (element_queue.size() == 0 && !in_valid);
		wait (inverse_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("matrix4x4_inverse_cofactor_unit test passed");
		else
			$display("matrix4x4_inverse_cofactor_unit test failed");
		$finish;
	end

endmodule
